// ----- sv/mpdp_pkg.sv -----
package mpdp_pkg;

  // Element precision codes, shared by the activation and weight registers
  typedef enum logic [1:0] {
    PREC_8 = 2'd0,
    PREC_4 = 2'd1,
    PREC_2 = 2'd2,
    PREC_1 = 2'd3
  } prec_e;

  localparam int WORD_W     = 64;
  localparam int COUNT_W    = 4;
  localparam int ELEM_W     = 8;
  localparam int PROD_W     = 2 * ELEM_W;
  localparam int OUT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACT_PREC    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_PREC = 2'd1;

  // Raw bits of one element position under each of the four packings
  typedef struct packed {
    logic [7:0] b8;
    logic [3:0] b4;
    logic [1:0] b2;
    logic       b1;
  } elem_bits_t;

  // Control that travels with one word into the pipeline
  typedef struct packed {
    logic vld;
    logic last;
  } beat_t;

  // Decode one element to a signed byte.
  // The 2-bit map {0, 1, -2, -1} is plain two's complement on two bits;
  // the 1-bit code maps 0 to +1 and 1 to -1.
  function automatic logic signed [ELEM_W-1:0] decode_elem(elem_bits_t bits, prec_e prec);
    logic signed [ELEM_W-1:0] val;
    case (prec)
      PREC_8:  val = bits.b8;
      PREC_4:  val = {{4{bits.b4[3]}}, bits.b4};
      PREC_2:  val = {{6{bits.b2[1]}}, bits.b2};
      PREC_1:  val = {{7{bits.b1}}, 1'b1};
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// ----- sv/mpdp_lane.sv -----
module mpdp_lane (
  input  logic                                 clk_i,
  input  logic                                 load_i,
  input  logic                                 en_i,
  input  mpdp_pkg::elem_bits_t                 act_bits_i,
  input  mpdp_pkg::elem_bits_t                 wgt_bits_i,
  input  mpdp_pkg::prec_e                      act_prec_i,
  input  mpdp_pkg::prec_e                      wgt_prec_i,
  output logic signed [mpdp_pkg::PROD_W-1:0]   prod_o
);

  logic signed [mpdp_pkg::ELEM_W-1:0] act_val;
  logic signed [mpdp_pkg::ELEM_W-1:0] wgt_val;
  logic signed [mpdp_pkg::PROD_W-1:0] prod_d;
  logic signed [mpdp_pkg::PROD_W-1:0] prod_q;

  // Decode both operands and multiply; drop pairs beyond the count
  always_comb begin
    act_val = mpdp_pkg::decode_elem(act_bits_i, act_prec_i);
    wgt_val = mpdp_pkg::decode_elem(wgt_bits_i, wgt_prec_i);
    prod_d  = '0;
    if (en_i) begin
      prod_d = act_val * wgt_val;
    end
  end

  // Hold the product until the next word is taken
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

// ----- sv/mpdp_merge.sv -----
module mpdp_merge #(
  parameter int PAIRS_PER_ITEM = 8,
  parameter int SUM_WIDTH      = 32
) (
  input  logic                                                clk_i,
  input  logic                                                rst_ni,
  input  mpdp_pkg::beat_t                                     beat_i,
  output logic                                                ready_o,
  input  logic [PAIRS_PER_ITEM-1:0][mpdp_pkg::PROD_W-1:0]     prods_i,
  input  logic                                                out_stall_i,
  output logic                                                out_valid_o,
  output logic signed [mpdp_pkg::OUT_W-1:0]                   dot_sum_o
);

  localparam int ProdW = mpdp_pkg::PROD_W;
  localparam int TreeW = ProdW + $clog2(PAIRS_PER_ITEM);
  localparam int OutW  = mpdp_pkg::OUT_W;

  // Product stage control (products live in the lanes)
  logic p_vld_q, p_vld_d;
  logic p_last_q, p_last_d;
  // Lane sum stage
  logic t_vld_q, t_vld_d;
  logic t_last_q, t_last_d;
  logic signed [TreeW-1:0] t_sum_q, t_sum_d;
  // Accumulator and output word
  logic [SUM_WIDTH-1:0] run_q, run_d;
  logic out_vld_q, out_vld_d;
  logic signed [OutW-1:0] out_sum_q, out_sum_d;

  logic signed [TreeW-1:0]     lane_sum;
  logic signed [ProdW-1:0]     prod_val;
  logic signed [SUM_WIDTH-1:0] acc_sum;
  logic out_free;
  logic s2_retire;
  logic s2_ready;
  logic s2_load;

  // Add the lane products
  always_comb begin
    lane_sum = '0;
    prod_val = '0;
    for (int i = 0; i < PAIRS_PER_ITEM; i++) begin
      prod_val = prods_i[i];
      lane_sum = lane_sum + TreeW'(prod_val);
    end
  end

  // Advance control: a sum stage word with last needs a free output slot
  always_comb begin
    out_free  = !out_vld_q || !out_stall_i;
    s2_retire = t_vld_q && (!t_last_q || out_free);
    s2_ready  = !t_vld_q || s2_retire;
    s2_load   = p_vld_q && s2_ready;
    ready_o   = !p_vld_q || s2_ready;
  end

  // Fold the lane sum into the running sum, clear it after the last word
  always_comb begin
    acc_sum   = run_q + SUM_WIDTH'(t_sum_q);
    p_vld_d   = beat_i.vld || (p_vld_q && !s2_ready);
    p_last_d  = beat_i.vld ? beat_i.last : p_last_q;
    t_vld_d   = s2_load || (t_vld_q && !s2_retire);
    t_last_d  = s2_load ? p_last_q : t_last_q;
    t_sum_d   = s2_load ? lane_sum : t_sum_q;
    run_d     = run_q;
    out_vld_d = out_vld_q && out_stall_i;
    out_sum_d = out_sum_q;
    if (s2_retire) begin
      if (t_last_q) begin
        run_d     = '0;
        out_vld_d = 1'b1;
        out_sum_d = OutW'(acc_sum);
      end else begin
        run_d = acc_sum;
      end
    end
  end

  // Hold control state and the running sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q   <= 1'b0;
      t_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
      run_q     <= '0;
    end else begin
      p_vld_q   <= p_vld_d;
      t_vld_q   <= t_vld_d;
      out_vld_q <= out_vld_d;
      run_q     <= run_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    p_last_q  <= p_last_d;
    t_last_q  <= t_last_d;
    t_sum_q   <= t_sum_d;
    out_sum_q <= out_sum_d;
  end

  assign out_valid_o = out_vld_q;
  assign dot_sum_o   = out_sum_q;

endmodule

// ----- sv/mixed_precision_dot_product_core.sv -----
// Mixed-precision dot product core. Each input word carries up to
// PAIRS_PER_ITEM packed activation/weight pairs whose widths (8, 4, 2 or
// 1 bits) are set by two configuration registers; pairs beyond count_i are
// ignored. Products are added into a SUM_WIDTH-bit wrapping running sum,
// and on a word with last_i set the finished sum appears on dot_sum_o and
// the running sum restarts at zero. The core takes one word per clock
// while in_stall_o is low: one lane per pair decodes and multiplies, a
// merge stage adds the lane products and accumulates, and an output
// register holds the result, so a sum passes the lane product, lane sum
// and output registers before it is on dot_sum_o. in_stall_o
// rises only when a finished sum is held by out_stall_i and the two
// pipeline stages behind it are full. Write the precision registers only
// while no words are in flight.
module mixed_precision_dot_product_core #(
  parameter int PAIRS_PER_ITEM = 8,
  parameter int SUM_WIDTH      = 32
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [mpdp_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [mpdp_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic [mpdp_pkg::WORD_W-1:0]             act_word_i,
  input  logic [mpdp_pkg::WORD_W-1:0]             weight_word_i,
  input  logic [mpdp_pkg::COUNT_W-1:0]            count_i,
  input  logic                                    last_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [mpdp_pkg::OUT_W-1:0]       dot_sum_o
);

  localparam int CntW  = mpdp_pkg::COUNT_W;
  localparam int ProdW = mpdp_pkg::PROD_W;

  mpdp_pkg::prec_e act_prec_q, act_prec_d;
  mpdp_pkg::prec_e wgt_prec_q, wgt_prec_d;

  logic                                  ready;
  logic                                  in_fire;
  mpdp_pkg::beat_t                       beat;
  logic [PAIRS_PER_ITEM-1:0][ProdW-1:0]  prods;

  // Decode configuration writes; ignore unknown indexes
  always_comb begin
    act_prec_d = act_prec_q;
    wgt_prec_d = wgt_prec_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        mpdp_pkg::CFG_ACT_PREC:    act_prec_d = mpdp_pkg::prec_e'(cfg_data_i);
        mpdp_pkg::CFG_WEIGHT_PREC: wgt_prec_d = mpdp_pkg::prec_e'(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_prec_q <= mpdp_pkg::PREC_8;
      wgt_prec_q <= mpdp_pkg::PREC_8;
    end else begin
      act_prec_q <= act_prec_d;
      wgt_prec_q <= wgt_prec_d;
    end
  end

  // Take a word whenever the product stage can move
  assign in_stall_o = !ready;
  assign in_fire    = in_valid_i && ready;
  assign beat.vld   = in_fire;
  assign beat.last  = last_i;

  // One lane per element pair
  for (genvar e = 0; e < PAIRS_PER_ITEM; e++) begin : g_lane
    mpdp_pkg::elem_bits_t act_bits;
    mpdp_pkg::elem_bits_t wgt_bits;

    assign act_bits.b8 = act_word_i[e*8 +: 8];
    assign act_bits.b4 = act_word_i[e*4 +: 4];
    assign act_bits.b2 = act_word_i[e*2 +: 2];
    assign act_bits.b1 = act_word_i[e];
    assign wgt_bits.b8 = weight_word_i[e*8 +: 8];
    assign wgt_bits.b4 = weight_word_i[e*4 +: 4];
    assign wgt_bits.b2 = weight_word_i[e*2 +: 2];
    assign wgt_bits.b1 = weight_word_i[e];

    mpdp_lane u_lane (
      .clk_i      (clk_i),
      .load_i     (in_fire),
      .en_i       (count_i > CntW'(e)),
      .act_bits_i (act_bits),
      .wgt_bits_i (wgt_bits),
      .act_prec_i (act_prec_q),
      .wgt_prec_i (wgt_prec_q),
      .prod_o     (prods[e])
    );
  end

  mpdp_merge #(
    .PAIRS_PER_ITEM (PAIRS_PER_ITEM),
    .SUM_WIDTH      (SUM_WIDTH)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (beat),
    .ready_o     (ready),
    .prods_i     (prods),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .dot_sum_o   (dot_sum_o)
  );

endmodule

// ----- sv/mpdp_checker.sv -----
module mpdp_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_i,
  input logic                              last_i,
  input logic                              out_valid_i,
  input logic                              out_stall_i,
  input logic [mpdp_pkg::OUT_W-1:0]        dot_sum_i
);

  // A stalled result word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(dot_sum_i))
    else $error("result word changed while stalled");

  // Input backs up only behind a blocked result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_i |-> out_valid_i && out_stall_i)
    else $error("input stalled while output is free");

  // A fresh result follows a taken last word
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && !in_stall_i && last_i, 3))
    else $error("result without a matching last word");

endmodule

bind mixed_precision_dot_product_core mpdp_checker u_mpdp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .last_i      (last_i),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .dot_sum_i   (dot_sum_o)
);
